/* rtl/core/pol_pkg.sv */
// Package with the shared types, codes and constants of the positional ordered list.
`timescale 1ns / 1ps

package pol_pkg;

   localparam int DATA_W       = 32;
   localparam int MODE_W       = 3;
   localparam int POS_W        = 6;
   localparam int LEN_W        = 7;
   localparam int STATUS_W     = 2;
   localparam int DEF_CAPACITY = 16;

   localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INS_END   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DEL_END   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DEL_POS   = 3'd5;
   localparam logic [MODE_W-1:0] MODE_READ_ALL  = 3'd6;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] element;
      logic                     element_valid;
      logic                     last;
      logic [LEN_W-1:0]         length;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INS,
      CELL_DEL,
      CELL_ROT
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type             cmd;
      logic [LEN_W-1:0]         pos;
      logic [LEN_W-1:0]         tail;
      logic signed [DATA_W-1:0] value;
   } cell_ctl_type;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

endpackage

/* rtl/core/positional_ordered_list.sv */
// Top level of the positional ordered list: control, count and the chain of cells.
// Insert and delete words answer with one status word.
// Read-all then gives one element word per cycle while the output register is free.
// A new request word is taken once the output register is free and no read-out is running.
// The chain rotates during read-out and is back in order when the last element leaves.
// Synchronous reset empties the list and the output register; cell contents are left as is.
`timescale 1ns / 1ps

module positional_ordered_list
   import pol_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic out_free;
   logic req_fire;
   logic rsp_load;
   logic start_read;
   logic read_last;
   logic [LEN_W-1:0] cnt_len;
   logic [LEN_W-1:0] pos_len;
   logic [LEN_W-1:0] idx_len;
   cell_ctl_type ctl;
   logic signed [DATA_W-1:0] cell_q [CAPACITY];

   assign cnt_len   = LEN_W'(cnt_ff);
   assign idx_len   = LEN_W'(idx_ff);
   assign pos_len   = {1'b0, req_data.position};
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign read_last = (idx_len + 1'b1) == cnt_len;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start_read) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (out_free && read_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      rsp_load   = 1'b0;
      start_read = 1'b0;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      rsp_in     = rsp_ff;
      ctl.cmd    = CELL_HOLD;
      ctl.pos    = '0;
      ctl.tail   = cnt_len - 1'b1;
      ctl.value  = req_data.value;
      case (state_ff)
         S_IDLE: begin
            req_ready            = out_free;
            rsp_in.element       = '0;
            rsp_in.element_valid = 1'b0;
            rsp_in.last          = 1'b1;
            rsp_in.status        = STATUS_OK;
            rsp_in.length        = cnt_len;
            if (req_fire) begin
               case (req_data.mode)
                  MODE_INS_FRONT, MODE_INS_END, MODE_INS_POS: begin
                     rsp_load = 1'b1;
                     if (req_data.mode == MODE_INS_FRONT) begin
                        ctl.pos = '0;
                     end else if (req_data.mode == MODE_INS_END) begin
                        ctl.pos = cnt_len;
                     end else begin
                        ctl.pos = pos_len;
                     end
                     if (cnt_len == CAP_LEN) begin
                        rsp_in.status = STATUS_FULL;
                     end else if (ctl.pos > cnt_len) begin
                        rsp_in.status = STATUS_INVALID;
                     end else begin
                        ctl.cmd       = CELL_INS;
                        cnt_in        = cnt_ff + 1'b1;
                        rsp_in.length = cnt_len + 1'b1;
                     end
                  end
                  MODE_DEL_FRONT, MODE_DEL_END, MODE_DEL_POS: begin
                     rsp_load = 1'b1;
                     if (req_data.mode == MODE_DEL_FRONT) begin
                        ctl.pos = '0;
                     end else if (req_data.mode == MODE_DEL_END) begin
                        ctl.pos = cnt_len - 1'b1;
                     end else begin
                        ctl.pos = pos_len;
                     end
                     if (cnt_len == '0) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else if (ctl.pos >= cnt_len) begin
                        rsp_in.status = STATUS_INVALID;
                     end else begin
                        ctl.cmd       = CELL_DEL;
                        cnt_in        = cnt_ff - 1'b1;
                        rsp_in.length = cnt_len - 1'b1;
                     end
                  end
                  MODE_READ_ALL: begin
                     if (cnt_len == '0) begin
                        rsp_load      = 1'b1;
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        start_read = 1'b1;
                        idx_in     = '0;
                     end
                  end
                  default: begin
                     rsp_load = 1'b0;
                  end
               endcase
            end
         end
         S_READ: begin
            if (out_free) begin
               rsp_load             = 1'b1;
               ctl.cmd              = CELL_ROT;
               idx_in               = idx_ff + 1'b1;
               rsp_in.status        = STATUS_OK;
               rsp_in.element       = cell_q[0];
               rsp_in.element_valid = 1'b1;
               rsp_in.last          = read_last;
               rsp_in.length        = cnt_len;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] prev_d;
      logic signed [DATA_W-1:0] next_d;
      if (i == 0) begin : g_first
         assign prev_d = '0;
      end else begin : g_mid_prev
         assign prev_d = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_final
         assign next_d = '0;
      end else begin : g_mid_next
         assign next_d = cell_q[i+1];
      end
      pol_cell #(
         .IDX(i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .prev_data (prev_d),
         .next_data (next_d),
         .first_data(cell_q[0]),
         .data      (cell_q[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_len <= CAP_LEN)
      else $error("element count exceeds capacity");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> cnt_len != '0)
      else $error("read-out running on an empty list");

   a_no_req_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> !req_ready)
      else $error("request taken during read-out");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (req_fire && cnt_len == CAP_LEN && (req_data.mode == MODE_INS_FRONT ||
       req_data.mode == MODE_INS_END || req_data.mode == MODE_INS_POS))
      |=> cnt_ff == $past(cnt_ff))
      else $error("insert into full list changed the count");
`endif

endmodule

/* rtl/core/pol_cell.sv */
// One storage cell of the list chain, holding the element at a fixed position.
`timescale 1ns / 1ps

module pol_cell
   import pol_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic                     clock,
   input  cell_ctl_type             ctl,
   input  logic signed [DATA_W-1:0] prev_data,
   input  logic signed [DATA_W-1:0] next_data,
   input  logic signed [DATA_W-1:0] first_data,
   output logic signed [DATA_W-1:0] data
);

   localparam logic [LEN_W-1:0] MY_POS = LEN_W'(IDX);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.cmd)
         CELL_INS: begin
            if (MY_POS == ctl.pos) begin
               data_in = ctl.value;
            end else if (MY_POS > ctl.pos) begin
               data_in = prev_data;
            end
         end
         CELL_DEL: begin
            if (MY_POS >= ctl.pos) begin
               data_in = next_data;
            end
         end
         CELL_ROT: begin
            if (MY_POS == ctl.tail) begin
               data_in = first_data;
            end else if (MY_POS < ctl.tail) begin
               data_in = next_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* verif/tb_positional_ordered_list.sv */
// Testbench for the positional ordered list: directed and random words checked against a predictor.
`timescale 1ns / 1ps

module tb_positional_ordered_list;
   import pol_pkg::*;

   localparam int CAPACITY = DEF_CAPACITY;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_MAX = 10;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic signed [DATA_W-1:0] list_mem [CAPACITY];
   int      list_len = 0;
   rsp_type expected_words [$];

   int send_idle_pct = 22;
   int recv_idle_pct = 53;
   int hold_request = 0;
   int hold_left = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   positional_ordered_list #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // The receiver stalls at random, or for a long stretch when one is requested.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Updates the list copy for one accepted word and queues the words it should produce.
   task automatic apply_word(input req_type w);
      rsp_type r;
      logic [STATUS_W-1:0] st;
      int p;
      r = '0;
      r.last = 1'b1;
      st = STATUS_OK;
      case (w.mode)
         MODE_INS_FRONT, MODE_INS_END, MODE_INS_POS: begin
            if (w.mode == MODE_INS_FRONT) p = 0;
            else if (w.mode == MODE_INS_END) p = list_len;
            else p = int'(w.position);
            if (list_len >= CAPACITY) begin
               st = STATUS_FULL;
            end else if (p > list_len) begin
               st = STATUS_INVALID;
            end else begin
               for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
               list_mem[p] = w.value;
               list_len++;
            end
         end
         MODE_DEL_FRONT, MODE_DEL_END, MODE_DEL_POS: begin
            if (w.mode == MODE_DEL_FRONT) p = 0;
            else if (w.mode == MODE_DEL_END) p = list_len - 1;
            else p = int'(w.position);
            if (list_len == 0) begin
               st = STATUS_EMPTY;
            end else if (p >= list_len) begin
               st = STATUS_INVALID;
            end else begin
               for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               list_len--;
            end
         end
         MODE_READ_ALL: begin
            if (list_len == 0) begin
               r.status = STATUS_EMPTY;
               expected_words.push_back(r);
            end else begin
               for (int i = 0; i < list_len; i++) begin
                  r.status = STATUS_OK;
                  r.element = list_mem[i];
                  r.element_valid = 1'b1;
                  r.last = (i + 1 == list_len);
                  r.length = LEN_W'(list_len);
                  expected_words.push_back(r);
               end
            end
            return;
         end
         default: return;
      endcase
      r.status = st;
      r.length = LEN_W'(list_len);
      expected_words.push_back(r);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("Unexpected result word %h", rsp_data);
         end else begin
            e = expected_words.pop_front();
            if (rsp_data.status !== e.status || rsp_data.element !== e.element ||
                rsp_data.element_valid !== e.element_valid || rsp_data.last !== e.last ||
                rsp_data.length !== e.length) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("Mismatch: expected st=%0d el=%0d ev=%b last=%b len=%0d, ",
                           e.status, e.element, e.element_valid, e.last, e.length,
                           "got st=%0d el=%0d ev=%b last=%b len=%0d",
                           rsp_data.status, rsp_data.element, rsp_data.element_valid,
                           rsp_data.last, rsp_data.length);
            end
         end
      end
   end

   // Valid stays high after acceptance so that back-to-back words need no extra assignment.
   task automatic send_word(input logic [MODE_W-1:0] mode, input logic signed [DATA_W-1:0] value,
                            input logic [POS_W-1:0] position);
      req_type w;
      w.mode = mode;
      w.value = value;
      w.position = position;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_word(w);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_list();
      send_word(MODE_READ_ALL, 0, 0);
      send_word(MODE_DEL_FRONT, 0, 0);
      send_word(MODE_DEL_END, 0, 0);
      send_word(MODE_DEL_POS, 0, 6'd63);
      send_word(MODE_INS_POS, 5, 6'd1);
      send_word(MODE_UNUSED, -1, 6'd63);
   endtask

   task automatic test_inserts();
      send_word(MODE_INS_FRONT, 32'sh8000_0000, 0);
      send_word(MODE_INS_END, 32'sh7FFF_FFFF, 0);
      send_word(MODE_INS_POS, -1, 6'd2);
      send_word(MODE_INS_POS, 0, 6'd1);
      send_word(MODE_INS_POS, 32'sh5555_AAAA, 6'd0);
      send_word(MODE_READ_ALL, 0, 0);
   endtask

   // The receiver holds off while the sender keeps offering words until the list is full.
   task automatic test_backpressure_fill();
      drain_results();
      hold_request = 400;
      while (list_len < CAPACITY) send_word(MODE_INS_END, $urandom, 0);
      send_word(MODE_INS_FRONT, 1, 0);
      send_word(MODE_INS_END, 2, 0);
      send_word(MODE_INS_POS, 3, 6'd63);
      send_word(MODE_READ_ALL, 0, 0);
   endtask

   task automatic test_deletes();
      send_word(MODE_DEL_POS, 0, 6'(list_len));
      send_word(MODE_DEL_POS, 0, 6'd63);
      send_word(MODE_DEL_POS, 0, 6'd7);
      send_word(MODE_DEL_END, 0, 0);
      send_word(MODE_DEL_FRONT, 0, 0);
      send_word(MODE_READ_ALL, 0, 0);
   endtask

   function automatic logic [MODE_W-1:0] MODE_MODE_PICK_INS();
      case ($urandom_range(0, 2))
         0: return MODE_INS_FRONT;
         1: return MODE_INS_END;
         default: return MODE_INS_POS;
      endcase
   endfunction

   function automatic logic [MODE_W-1:0] MODE_MODE_PICK_DEL();
      case ($urandom_range(0, 2))
         0: return MODE_DEL_FRONT;
         1: return MODE_DEL_END;
         default: return MODE_DEL_POS;
      endcase
   endfunction

   task automatic test_random(input int words, input int insert_pct);
      logic [MODE_W-1:0] mode;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0] position;
      int n;
      int pick;
      n = 0;
      while (n < words) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) mode = MODE_UNUSED;
         else if (pick < 13) mode = MODE_READ_ALL;
         else if ($urandom_range(0, 99) < insert_pct) mode = MODE_MODE_PICK_INS();
         else mode = MODE_MODE_PICK_DEL();
         case ($urandom_range(0, 9))
            0: value = 32'sh8000_0000;
            1: value = 32'sh7FFF_FFFF;
            default: value = $urandom;
         endcase
         if ($urandom_range(0, 3) == 0) position = POS_W'($urandom_range(0, 63));
         else if (mode == MODE_DEL_POS && list_len > 0)
            position = POS_W'($urandom_range(0, list_len - 1));
         else position = POS_W'($urandom_range(0, list_len));
         send_word(mode, value, position);
         if (mode != MODE_UNUSED) n++;
      end
      drain_results();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_inserts();
      test_backpressure_fill();
      test_deletes();
      drain_results();
      test_random(30, 70);
      send_idle_pct = 53;
      recv_idle_pct = 22;
      test_random(30, 30);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(30, 50);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
